// File: design/tlpt_pkg.sv
// ----------------------------------------------------------------------------
// tlpt_pkg
// Shared types and constants for the two-level page table: beat payloads,
// operation codes, address field positions and controller/datapath links.
// ----------------------------------------------------------------------------
package tlpt_pkg;

  // Address layout
  localparam int ADDR_W      = 32;
  localparam int FLAGS_W     = 12;
  localparam int IDX_W       = 10;
  localparam int PD_LSB      = 22;
  localparam int PT_LSB      = 12;
  localparam int OFFSET_W    = 12;
  localparam int OP_W        = 2;
  localparam int SPACE_W     = 2;

  localparam int DIR_ENTRIES   = 1024;
  localparam int TABLE_ENTRIES = 1024;

  // Parameter defaults
  localparam int SPACES_DEF      = 4;
  localparam int TABLE_SLOTS_DEF = 16;

  // Operation codes
  localparam logic [OP_W-1:0] OP_MAP       = 2'd0;
  localparam logic [OP_W-1:0] OP_UNMAP     = 2'd1;
  localparam logic [OP_W-1:0] OP_TRANSLATE = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE      = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [SPACE_W-1:0] address_space;
    logic [ADDR_W-1:0]  virtual_address;
    logic [ADDR_W-1:0]  map_frame_address;
    logic [FLAGS_W-1:0] entry_flags;
  } tlpt_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] translated_address;
    logic              found;
    logic              table_full;
  } tlpt_out_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;      // write one clearing entry
    logic accept;     // latch item, read directory
    logic tbl_issue;  // read table entry
    logic dir_done;   // finish item after directory lookup
    logic tbl_done;   // finish translate after table lookup
  } tlpt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_done;
    logic need_table;
    logic out_free;
  } tlpt_status_t;

endpackage

// File: design/tlpt_ram.sv
// ----------------------------------------------------------------------------
// tlpt_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tlpt_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 1024,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/tlpt_ctrl.sv
// ----------------------------------------------------------------------------
// tlpt_ctrl
// Sequencer for the page table: clearing pass, accept, directory lookup,
// optional table lookup, result load.
// ----------------------------------------------------------------------------
module tlpt_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  tlpt_pkg::tlpt_status_t st,
  output tlpt_pkg::tlpt_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_DIR   = 4'b0100,
    S_TBL   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (st.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DIR;
        end
      end
      S_DIR: begin
        if (st.need_table) begin
          cmd.tbl_issue = 1'b1;
          state_nxt     = S_TBL;
        end else if (st.out_free) begin
          cmd.dir_done = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_TBL: begin
        // hold the table data until the output register frees up
        if (st.out_free) begin
          cmd.tbl_done = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: design/tlpt_dp.sv
// ----------------------------------------------------------------------------
// tlpt_dp
// Page table datapath: directory and table memories, item register, slot
// allocator, clearing counter and output register.
// ----------------------------------------------------------------------------
module tlpt_dp #(
  parameter int SPACES      = tlpt_pkg::SPACES_DEF,
  parameter int TABLE_SLOTS = tlpt_pkg::TABLE_SLOTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tlpt_pkg::tlpt_cmd_t    cmd,
  output tlpt_pkg::tlpt_status_t st,
  input  tlpt_pkg::tlpt_in_t     in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output tlpt_pkg::tlpt_out_t    out_data
);

  localparam int DIR_DEPTH = SPACES * tlpt_pkg::DIR_ENTRIES;
  localparam int DIR_AW    = $clog2(DIR_DEPTH);
  localparam int SLOT_W    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int DIR_W     = SLOT_W + 1;
  localparam int TBL_DEPTH = TABLE_SLOTS * tlpt_pkg::TABLE_ENTRIES;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int CNT_W     = $clog2(TABLE_SLOTS + 1);
  localparam int CLR_DEPTH = (TBL_DEPTH > DIR_DEPTH) ? TBL_DEPTH : DIR_DEPTH;
  localparam int CLR_W     = $clog2(CLR_DEPTH);
  localparam int IDX_W     = tlpt_pkg::IDX_W;
  localparam int ADDR_W    = tlpt_pkg::ADDR_W;
  localparam int OFFSET_W  = tlpt_pkg::OFFSET_W;

  tlpt_pkg::tlpt_in_t  item_r;
  tlpt_pkg::tlpt_out_t out_data_r, out_data_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CLR_W-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic [CNT_W-1:0]    next_free_r, next_free_nxt;

  logic              dir_we, dir_re;
  logic [DIR_AW-1:0] dir_waddr, dir_raddr;
  logic [DIR_W-1:0]  dir_wdata, dir_rdata;
  logic              tbl_we, tbl_re;
  logic [TBL_AW-1:0] tbl_waddr, tbl_raddr;
  logic [ADDR_W-1:0] tbl_wdata, tbl_rdata;

  logic [IDX_W-1:0]  pt_idx;
  logic [DIR_AW-1:0] item_dir_addr;
  logic              space_ok, live, is_map, is_unmap, is_xlate;
  logic              present, slots_used_up, alloc, map_fail, tbl_write;
  logic [SLOT_W-1:0] dir_slot, new_slot, use_slot;

  // --- item decode -----------------------------------------------------------
  assign pt_idx        = item_r.virtual_address[tlpt_pkg::PT_LSB +: IDX_W];
  assign item_dir_addr = DIR_AW'({item_r.address_space,
                                  item_r.virtual_address[tlpt_pkg::PD_LSB +: IDX_W]});
  assign space_ok      = (32'(item_r.address_space) < SPACES);
  assign live          = space_ok && (item_r.operation != tlpt_pkg::OP_NONE);
  assign is_map        = live && (item_r.operation == tlpt_pkg::OP_MAP);
  assign is_unmap      = live && (item_r.operation == tlpt_pkg::OP_UNMAP);
  assign is_xlate      = live && (item_r.operation == tlpt_pkg::OP_TRANSLATE);

  assign present       = dir_rdata[DIR_W-1];
  assign dir_slot      = dir_rdata[SLOT_W-1:0];
  assign slots_used_up = (next_free_r == CNT_W'(TABLE_SLOTS));
  assign new_slot      = next_free_r[SLOT_W-1:0];
  assign alloc         = is_map && !present && !slots_used_up;
  assign map_fail      = is_map && !present && slots_used_up;
  assign use_slot      = present ? dir_slot : new_slot;
  assign tbl_write     = (is_map && (present || alloc)) || (is_unmap && present);

  // --- memory ports ----------------------------------------------------------
  assign dir_re    = cmd.accept;
  assign dir_raddr = DIR_AW'({in_data.address_space,
                              in_data.virtual_address[tlpt_pkg::PD_LSB +: IDX_W]});
  assign tbl_re    = cmd.tbl_issue;
  assign tbl_raddr = TBL_AW'({dir_slot, pt_idx});

  always_comb begin
    dir_we    = 1'b0;
    dir_waddr = item_dir_addr;
    dir_wdata = {1'b1, new_slot};
    tbl_we    = 1'b0;
    tbl_waddr = TBL_AW'({use_slot, pt_idx});
    tbl_wdata = is_map ? (item_r.map_frame_address | ADDR_W'(item_r.entry_flags)) : '0;
    if (cmd.clear) begin
      dir_we    = (32'(clr_cnt_r) < DIR_DEPTH);
      dir_waddr = DIR_AW'(clr_cnt_r);
      dir_wdata = '0;
      tbl_we    = (32'(clr_cnt_r) < TBL_DEPTH);
      tbl_waddr = TBL_AW'(clr_cnt_r);
      tbl_wdata = '0;
    end else if (cmd.dir_done) begin
      dir_we = alloc;
      tbl_we = tbl_write;
    end
  end

  tlpt_ram #(
    .WIDTH (DIR_W),
    .DEPTH (DIR_DEPTH)
  ) u_dir_ram (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .re    (dir_re),
    .raddr (dir_raddr),
    .rdata (dir_rdata)
  );

  tlpt_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (TBL_DEPTH)
  ) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // --- counters and output register ------------------------------------------
  assign clr_cnt_nxt   = cmd.clear ? clr_cnt_r + 1'b1 : clr_cnt_r;
  assign next_free_nxt = (cmd.dir_done && alloc) ? next_free_r + 1'b1 : next_free_r;

  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.dir_done) begin
      out_data_nxt.translated_address = '0;
      out_data_nxt.found              = 1'b0;
      out_data_nxt.table_full         = map_fail;
      out_valid_nxt                   = 1'b1;
    end else if (cmd.tbl_done) begin
      // present bit of the table entry decides the hit
      out_data_nxt.found              = tbl_rdata[0];
      out_data_nxt.translated_address = tbl_rdata[0] ?
          {tbl_rdata[ADDR_W-1:OFFSET_W], item_r.virtual_address[OFFSET_W-1:0]} : '0;
      out_data_nxt.table_full         = 1'b0;
      out_valid_nxt                   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      next_free_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      clr_cnt_r   <= clr_cnt_nxt;
      next_free_r <= next_free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r <= in_data;
    end
    out_data_r <= out_data_nxt;
  end

  // --- status ----------------------------------------------------------------
  assign st.clr_done   = (clr_cnt_r == CLR_W'(CLR_DEPTH - 1));
  assign st.need_table = is_xlate && present;
  assign st.out_free   = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: design/two_level_page_table.sv
// ----------------------------------------------------------------------------
// two_level_page_table
// Two-level radix page table for several address spaces: map, unmap and
// translate on directory and table memories with bump slot allocation.
// ----------------------------------------------------------------------------
//   channel | ports                          | payload
//   input   | in_valid, in_stall, in_data    | tlpt_in_t
//   result  | out_valid, out_stall, out_data | tlpt_out_t
//
// Map, unmap, ignored items and translates that miss the directory finish
// after the registered directory read; a translate that finds its directory
// entry present also goes through the registered table read before its
// result is loaded.
// After reset a clearing pass writes both memories one entry a cycle over
// max(SPACES, TABLE_SLOTS) * 1024 addresses (16384 by default) with in_stall high.
// A stalled result holds in the output register; the next item is taken while
// it waits, and its own result waits until the register is free.
// ----------------------------------------------------------------------------
module two_level_page_table #(
  parameter int SPACES      = tlpt_pkg::SPACES_DEF,
  parameter int TABLE_SLOTS = tlpt_pkg::TABLE_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tlpt_pkg::tlpt_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tlpt_pkg::tlpt_out_t out_data
);

  tlpt_pkg::tlpt_cmd_t    cmd;
  tlpt_pkg::tlpt_status_t st;

  tlpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  tlpt_dp #(
    .SPACES      (SPACES),
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: design/tlpt_checker.sv
// ----------------------------------------------------------------------------
// tlpt_checker
// Port-level checks for the page table, attached to the top level by bind.
// ----------------------------------------------------------------------------
module tlpt_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input tlpt_pkg::tlpt_out_t out_data
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // one item at a time: an accept closes the input side
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in flight");

  // a new result only comes out of a lookup in flight
  a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in flight");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.translated_address == '0)
    else $error("miss carries a nonzero address");

  a_full_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.found && out_data.table_full))
    else $error("hit and table full on one result");

endmodule

bind two_level_page_table tlpt_checker u_tlpt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: tb/tb_two_level_page_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_level_page_table
// Self-checking bench for the two-level page table. A directed table walks
// empty lookups, map/translate/unmap at the address extremes, entries without
// the present bit and table slot exhaustion, with per-row expected results;
// random map, unmap and translate beats over a small pool of directory and
// table indexes follow, checked against a bench-side directory and table copy.
// ----------------------------------------------------------------------------
module tb_two_level_page_table;

  localparam int N_SPACES     = tlpt_pkg::SPACES_DEF;
  localparam int N_SLOTS      = tlpt_pkg::TABLE_SLOTS_DEF;
  localparam int N_DIR        = tlpt_pkg::DIR_ENTRIES;
  localparam int N_TBL        = tlpt_pkg::TABLE_ENTRIES;
  localparam int RANDOM_BEATS = 1200;
  localparam int N_DIRECTED   = 27;

  localparam tlpt_pkg::tlpt_out_t NO_HIT   = '{32'h0, 1'b0, 1'b0};
  localparam tlpt_pkg::tlpt_out_t NO_TABLE = '{32'h0, 1'b0, 1'b1};

  typedef struct packed {
    tlpt_pkg::tlpt_in_t  item;
    bit                  typed;
    tlpt_pkg::tlpt_out_t want;
  } directed_row_t;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  tlpt_pkg::tlpt_in_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  tlpt_pkg::tlpt_out_t out_data;

  // bench copy of the page table state
  bit          dir_present [N_SPACES*N_DIR];
  int unsigned dir_slot    [N_SPACES*N_DIR];
  bit [31:0]   page_entry  [N_SLOTS*N_TBL];
  int unsigned slots_used = 0;

  tlpt_pkg::tlpt_out_t pending [$];
  int        mismatches = 0;
  int        burst_left = 0;
  int        stall_left = 0;
  int        stall_mode = 0;

  directed_row_t directed_rows [N_DIRECTED] = '{
    '{'{tlpt_pkg::OP_TRANSLATE, 2'd0, 32'h0000_0000, 32'h0000_0000, 12'h000}, 1'b1, NO_HIT},
    '{'{tlpt_pkg::OP_UNMAP, 2'd3, 32'hFFFF_FFFF, 32'h0000_0000, 12'h000}, 1'b1, NO_HIT},
    '{'{tlpt_pkg::OP_NONE, 2'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF}, 1'b1, NO_HIT},
    '{'{tlpt_pkg::OP_MAP, 2'd0, 32'h0000_0000, 32'hFFFF_F000, 12'h001}, 1'b1, NO_HIT},
    '{'{tlpt_pkg::OP_TRANSLATE, 2'd0, 32'h0000_0ABC, 32'h0000_0000, 12'h000}, 1'b1,
      '{32'hFFFF_FABC, 1'b1, 1'b0}},
    '{'{tlpt_pkg::OP_MAP, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF}, 1'b1, NO_HIT},
    '{'{tlpt_pkg::OP_TRANSLATE, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF}, 1'b1,
      '{32'hFFFF_FFFF, 1'b1, 1'b0}},
    '{'{tlpt_pkg::OP_MAP, 2'd1, 32'h0040_1000, 32'h1234_5000, 12'h000}, 1'b1, NO_HIT},
    '{'{tlpt_pkg::OP_TRANSLATE, 2'd1, 32'h0040_1234, 32'h0000_0000, 12'h000}, 1'b1, NO_HIT},
    '{'{tlpt_pkg::OP_UNMAP, 2'd0, 32'h0000_0000, 32'h0000_0000, 12'h000}, 1'b1, NO_HIT},
    '{'{tlpt_pkg::OP_TRANSLATE, 2'd0, 32'h0000_0FFF, 32'h0000_0000, 12'h000}, 1'b1, NO_HIT},
    '{'{tlpt_pkg::OP_MAP, 2'd2, 32'h8000_0000, 32'h0000_0FFE, 12'h001}, 1'b0, NO_HIT},
    '{'{tlpt_pkg::OP_TRANSLATE, 2'd2, 32'h8000_0123, 32'h0000_0000, 12'h000}, 1'b0, NO_HIT},
    // use up the remaining table slots
    '{'{tlpt_pkg::OP_MAP, 2'd0, 32'h0040_1000, 32'hA000_1000, 12'h003}, 1'b1, NO_HIT},
    '{'{tlpt_pkg::OP_MAP, 2'd0, 32'h0080_2000, 32'hA000_2000, 12'h003}, 1'b1, NO_HIT},
    '{'{tlpt_pkg::OP_MAP, 2'd0, 32'h00C0_3000, 32'hA000_3000, 12'h003}, 1'b1, NO_HIT},
    '{'{tlpt_pkg::OP_MAP, 2'd0, 32'h0100_4000, 32'hA000_4000, 12'h003}, 1'b1, NO_HIT},
    '{'{tlpt_pkg::OP_MAP, 2'd0, 32'h0140_5000, 32'hA000_5000, 12'h003}, 1'b1, NO_HIT},
    '{'{tlpt_pkg::OP_MAP, 2'd0, 32'h0180_6000, 32'hA000_6000, 12'h003}, 1'b1, NO_HIT},
    '{'{tlpt_pkg::OP_MAP, 2'd0, 32'h01C0_7000, 32'hA000_7000, 12'h003}, 1'b1, NO_HIT},
    '{'{tlpt_pkg::OP_MAP, 2'd0, 32'h0200_8000, 32'hA000_8000, 12'h003}, 1'b1, NO_HIT},
    '{'{tlpt_pkg::OP_MAP, 2'd0, 32'h0240_9000, 32'hA000_9000, 12'h003}, 1'b1, NO_HIT},
    '{'{tlpt_pkg::OP_MAP, 2'd0, 32'h0280_A000, 32'hA000_A000, 12'h003}, 1'b1, NO_HIT},
    '{'{tlpt_pkg::OP_MAP, 2'd0, 32'h02C0_B000, 32'hA000_B000, 12'h003}, 1'b1, NO_HIT},
    '{'{tlpt_pkg::OP_MAP, 2'd0, 32'h0300_C000, 32'hA000_C000, 12'h003}, 1'b1, NO_HIT},
    // no slot left for a new directory entry
    '{'{tlpt_pkg::OP_MAP, 2'd1, 32'h00C0_0000, 32'h5555_5000, 12'h001}, 1'b1, NO_TABLE},
    '{'{tlpt_pkg::OP_TRANSLATE, 2'd1, 32'h00C0_0000, 32'h0000_0000, 12'h000}, 1'b1, NO_HIT}
  };

  two_level_page_table u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Walk the bench copy of the tables for one accepted beat.
  function automatic tlpt_pkg::tlpt_out_t walk_tables(input tlpt_pkg::tlpt_in_t it);
    tlpt_pkg::tlpt_out_t res;
    int unsigned dir_idx;
    int unsigned tbl_idx;
    bit [31:0]   entry;
    res = '0;
    if (it.operation == tlpt_pkg::OP_NONE || it.address_space >= N_SPACES) return res;
    dir_idx = it.address_space * N_DIR + it.virtual_address[31:22];
    tbl_idx = dir_slot[dir_idx] * N_TBL + it.virtual_address[21:12];
    case (it.operation)
      tlpt_pkg::OP_MAP: begin
        if (!dir_present[dir_idx]) begin
          if (slots_used >= N_SLOTS) begin
            res.table_full = 1'b1;
          end else begin
            dir_present[dir_idx] = 1'b1;
            dir_slot[dir_idx]    = slots_used;
            tbl_idx = slots_used * N_TBL + it.virtual_address[21:12];
            slots_used++;
          end
        end
        if (!res.table_full)
          page_entry[tbl_idx] = it.map_frame_address | {20'h0, it.entry_flags};
      end
      tlpt_pkg::OP_UNMAP: begin
        if (dir_present[dir_idx]) page_entry[tbl_idx] = '0;
      end
      default: begin
        entry = page_entry[tbl_idx];
        if (dir_present[dir_idx] && entry[0]) begin
          res.translated_address = {entry[31:12], it.virtual_address[11:0]};
          res.found = 1'b1;
        end
      end
    endcase
    return res;
  endfunction

  // Mostly a small pool of directory and table indexes so lookups hit.
  function automatic tlpt_pkg::tlpt_in_t random_item();
    tlpt_pkg::tlpt_in_t it;
    int unsigned pick;
    logic [9:0]  pd;
    logic [9:0]  pt;
    pick = $urandom_range(0, 99);
    if (pick < 35)      it.operation = tlpt_pkg::OP_MAP;
    else if (pick < 50) it.operation = tlpt_pkg::OP_UNMAP;
    else if (pick < 95) it.operation = tlpt_pkg::OP_TRANSLATE;
    else                it.operation = tlpt_pkg::OP_NONE;
    it.address_space = $urandom_range(0, 1) ? 2'd0 : 2'($urandom_range(0, 3));
    pick = $urandom_range(0, 9);
    if (pick < 7)       pd = 10'($urandom_range(0, 13));
    else if (pick == 7) pd = 10'h3FF;
    else if (pick == 8) pd = 10'h200;
    else                pd = 10'($urandom_range(0, 1023));
    pt = ($urandom_range(0, 4) != 0) ? 10'($urandom_range(0, 7))
                                     : 10'($urandom_range(0, 1023));
    it.virtual_address   = {pd, pt, 12'($urandom)};
    it.map_frame_address = $urandom;
    it.entry_flags       = 12'($urandom_range(0, 4095));
    it.entry_flags[0]    = ($urandom_range(0, 4) != 0);
    return it;
  endfunction

  // Present one beat, hold it until taken, then record what it should produce.
  task automatic send_item(input tlpt_pkg::tlpt_in_t item, input bit typed,
                           input tlpt_pkg::tlpt_out_t want);
    tlpt_pkg::tlpt_out_t predicted;
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = walk_tables(item);
    pending.push_back(typed ? want : predicted);
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
  endtask

  // Receiver: switch between no stall, light stall and heavy stall.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin : check_results
    tlpt_pkg::tlpt_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result beat with nothing pending: addr=%h found=%b full=%b",
                   $realtime, out_data.translated_address, out_data.found,
                   out_data.table_full);
      end else begin
        want = pending.pop_front();
        if (out_data.translated_address !== want.translated_address ||
            out_data.found !== want.found || out_data.table_full !== want.table_full) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch exp addr=%h found=%b full=%b, got addr=%h found=%b full=%b",
                     $realtime, want.translated_address, want.found, want.table_full,
                     out_data.translated_address, out_data.found, out_data.table_full);
        end
      end
    end
  end

  initial begin : stimulus
    tlpt_pkg::tlpt_in_t item;
    int       sent;
    sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      pace_sender();
    end
    drain_results();

    while (sent < RANDOM_BEATS) begin
      item = random_item();
      send_item(item, 1'b0, NO_HIT);
      if (item.operation != tlpt_pkg::OP_NONE) sent++;
      // hold off mid-run until every result is back
      if (sent == RANDOM_BEATS / 2 && item.operation != tlpt_pkg::OP_NONE) drain_results();
      else pace_sender();
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// File: files.f
design/tlpt_pkg.sv
design/tlpt_ram.sv
design/tlpt_ctrl.sv
design/tlpt_dp.sv
design/two_level_page_table.sv
design/tlpt_checker.sv
tb/tb_two_level_page_table.sv
